### src/cfd_pkg.sv
package cfd_pkg;

  // Field index width; the counter saturates at its all-ones value
  localparam int FIELD_INDEX_BITS = 8;
  localparam logic [FIELD_INDEX_BITS-1:0] FIELD_MAX = '1;
  // Width used to clamp the field index to the 8-bit output field
  localparam int FN_W = (FIELD_INDEX_BITS > 8) ? FIELD_INDEX_BITS : 8;

  // Per-field character limit register
  localparam int LIMIT_W = 12;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2046;

  // Special bytes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Token queue between classifier and parser (depth a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [7:0] field_number;
    logic       truncated;
  } out_item_t;

  typedef enum logic [1:0] {
    TOK_CHAR,
    TOK_QUOTE,
    TOK_COMMA,
    TOK_EOL
  } tok_cls_t;

  typedef struct packed {
    tok_cls_t   cls;
    logic [7:0] ch;
  } token_t;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_PLAIN_Q,
    MODE_QUOTED,
    MODE_QUOTED_Q,
    MODE_SKIP
  } parse_mode_t;

  // Queue head seen by the back end: valid flag and the oldest token
  typedef struct packed {
    logic   valid;
    token_t tok;
  } q_out_t;

endpackage

### src/cfd_front.sv
module cfd_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  cfd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output cfd_pkg::token_t   push_tok
);

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Classify the byte into a parser token
  always_comb begin
    push_tok.ch = in_data.char_code;
    if (in_data.end_of_line) begin
      push_tok.cls = cfd_pkg::TOK_EOL;
    end else if (in_data.char_code == cfd_pkg::CH_QUOTE) begin
      push_tok.cls = cfd_pkg::TOK_QUOTE;
    end else if (in_data.char_code == cfd_pkg::CH_COMMA) begin
      push_tok.cls = cfd_pkg::TOK_COMMA;
    end else begin
      push_tok.cls = cfd_pkg::TOK_CHAR;
    end
  end

endmodule

### src/cfd_queue.sv
module cfd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cfd_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output cfd_pkg::q_out_t head
);

  cfd_pkg::token_t                mem [cfd_pkg::QUEUE_DEPTH];
  logic [cfd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [cfd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [cfd_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign full       = (count_r == cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.tok   = mem[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH))
    else $error("token queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty token queue");

endmodule

### src/cfd_back.sv
module cfd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cfd_pkg::LIMIT_W-1:0]   limit,
  input  cfd_pkg::q_out_t               head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cfd_pkg::out_item_t            out_data
);

  cfd_pkg::parse_mode_t                   mode_r, mode_nxt;
  logic [cfd_pkg::LIMIT_W-1:0]            kept_r, kept_nxt;
  logic [cfd_pkg::FIELD_INDEX_BITS-1:0]   field_r, field_nxt;
  logic                                   drop_r, drop_nxt;
  logic                                   out_valid_r;
  cfd_pkg::out_item_t                     out_r;

  logic                    res_vld;
  cfd_pkg::out_item_t      res;
  logic                    want_char, want_end, want_err;
  logic [cfd_pkg::FN_W-1:0] field_ext;
  cfd_pkg::token_t         tok;

  assign tok       = head.tok;
  // Take the next token when the output register is free or draining
  assign pop       = head.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Field index widened to FN_W bits; it is clamped to 255 where the result is built
  assign field_ext = cfd_pkg::FN_W'(field_r);

  // Parser: next mode, counters and result for the head token
  always_comb begin
    mode_nxt  = mode_r;
    kept_nxt  = kept_r;
    field_nxt = field_r;
    drop_nxt  = drop_r;
    want_char = 1'b0;
    want_end  = 1'b0;
    want_err  = 1'b0;
    res_vld   = 1'b0;
    res.kind         = cfd_pkg::KIND_CHAR;
    res.out_char     = '0;
    res.truncated    = 1'b0;
    res.field_number = (field_ext > cfd_pkg::FN_W'(255)) ? 8'hFF : field_ext[7:0];

    if (tok.cls == cfd_pkg::TOK_EOL) begin
      unique case (mode_r) inside
        cfd_pkg::MODE_START, cfd_pkg::MODE_PLAIN, cfd_pkg::MODE_QUOTED_Q: begin
          res_vld       = 1'b1;
          res.kind      = cfd_pkg::KIND_LINE;
          res.truncated = drop_r;
        end
        cfd_pkg::MODE_QUOTED, cfd_pkg::MODE_PLAIN_Q: begin
          res_vld  = 1'b1;
          res.kind = cfd_pkg::KIND_ERROR;
        end
        default: ;
      endcase
      // Fresh line
      mode_nxt  = cfd_pkg::MODE_START;
      kept_nxt  = '0;
      field_nxt = '0;
      drop_nxt  = 1'b0;
    end else begin
      unique case (mode_r)
        cfd_pkg::MODE_START: begin
          if (tok.cls == cfd_pkg::TOK_QUOTE) begin
            mode_nxt = cfd_pkg::MODE_QUOTED;
          end else if (tok.cls == cfd_pkg::TOK_COMMA) begin
            want_end = 1'b1;
          end else begin
            mode_nxt  = cfd_pkg::MODE_PLAIN;
            want_char = 1'b1;
          end
        end
        cfd_pkg::MODE_PLAIN: begin
          if (tok.cls == cfd_pkg::TOK_COMMA) begin
            want_end = 1'b1;
          end else if (tok.cls == cfd_pkg::TOK_QUOTE) begin
            mode_nxt = cfd_pkg::MODE_PLAIN_Q;
          end else begin
            want_char = 1'b1;
          end
        end
        cfd_pkg::MODE_PLAIN_Q: begin
          if (tok.cls == cfd_pkg::TOK_QUOTE) begin
            mode_nxt  = cfd_pkg::MODE_PLAIN;
            want_char = 1'b1;
          end else begin
            want_err = 1'b1;
          end
        end
        cfd_pkg::MODE_QUOTED: begin
          if (tok.cls == cfd_pkg::TOK_QUOTE) begin
            mode_nxt = cfd_pkg::MODE_QUOTED_Q;
          end else begin
            want_char = 1'b1;
          end
        end
        cfd_pkg::MODE_QUOTED_Q: begin
          if (tok.cls == cfd_pkg::TOK_QUOTE) begin
            mode_nxt  = cfd_pkg::MODE_QUOTED;
            want_char = 1'b1;
          end else if (tok.cls == cfd_pkg::TOK_COMMA) begin
            want_end = 1'b1;
          end else begin
            want_err = 1'b1;
          end
        end
        default: begin
          mode_nxt = cfd_pkg::MODE_SKIP;
        end
      endcase

      // Keep the character while under the limit, else mark the field
      if (want_char) begin
        if (kept_r < limit) begin
          kept_nxt     = kept_r + 1'b1;
          res_vld      = 1'b1;
          res.out_char = tok.ch;
        end else begin
          drop_nxt = 1'b1;
        end
      end

      // Field end
      if (want_end) begin
        res_vld       = 1'b1;
        res.kind      = cfd_pkg::KIND_FIELD;
        res.truncated = drop_r;
        if (field_r != cfd_pkg::FIELD_MAX) begin
          field_nxt = field_r + 1'b1;
        end
        kept_nxt = '0;
        drop_nxt = 1'b0;
        mode_nxt = cfd_pkg::MODE_START;
      end

      // Format error: skip to end of line
      if (want_err) begin
        res_vld  = 1'b1;
        res.kind = cfd_pkg::KIND_ERROR;
        mode_nxt = cfd_pkg::MODE_SKIP;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cfd_pkg::MODE_START;
      kept_r  <= '0;
      field_r <= '0;
      drop_r  <= 1'b0;
    end else if (pop) begin
      mode_r  <= mode_nxt;
      kept_r  <= kept_nxt;
      field_r <= field_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_vld) begin
      out_r <= res;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid right after reset");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (tok.cls == cfd_pkg::TOK_EOL) |=>
      (mode_r == cfd_pkg::MODE_START) && (kept_r == '0) && (field_r == '0) && !drop_r)
    else $error("line end did not restart the parser");

  a_char_not_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.kind == cfd_pkg::KIND_CHAR) |-> !out_r.truncated)
    else $error("character result flagged truncated");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !pop)
    else $error("parser advanced while output stalled");

endmodule

### src/csv_line_field_decoder.sv
// CSV line field decoder: one byte (or end-of-line mark) per transfer.
// Throughput: one input item per cycle, sustained while the output is taken.
// Path: the token queue stores each byte as it is transferred, and the parser loads
// the output register when it pops the token; tokens that give no result load nothing.
// Reset (rst_n low, synchronous): queue and output empty, parser at field
// start with counters cleared, character limit back to 2046.
module csv_line_field_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cfd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cfd_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [cfd_pkg::LIMIT_W-1:0]   cfg_wdata
);

  logic [cfd_pkg::LIMIT_W-1:0] limit_r;
  logic                        q_full;
  logic                        push;
  cfd_pkg::token_t             push_tok;
  logic                        pop;
  cfd_pkg::q_out_t             head;

  // Character limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= cfd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  cfd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  cfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  cfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
